@@ design/psq_pkg.sv @@
// Package: types, sizes and codes shared by the priority stack queue modules.
`timescale 1ns / 1ps
package psq_pkg;

    localparam int CAPACITY     = 16;
    localparam int ELEMENT_BITS = 32;
    localparam int PRIO_BITS    = 16;
    localparam int COUNT_BITS   = $clog2(CAPACITY + 1);

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        opcode_t                 opcode;
        logic [ELEMENT_BITS-1:0] element;
        logic [PRIO_BITS-1:0]    prio;
    } in_t;

    typedef struct packed {
        logic [ELEMENT_BITS-1:0] front_element;
        logic [PRIO_BITS-1:0]    front_prio;
        logic [COUNT_BITS-1:0]   count;
        logic                    is_empty;
        status_t                 status;
    } out_t;

    typedef struct packed {
        logic                    valid;
        logic [ELEMENT_BITS-1:0] element;
        logic [PRIO_BITS-1:0]    prio;
    } entry_t;

    typedef struct packed {
        logic                    push;
        logic                    pop;
        logic [ELEMENT_BITS-1:0] element;
        logic [PRIO_BITS-1:0]    prio;
    } cell_ctrl_t;

endpackage

@@ design/psq_cell.sv @@
// One storage cell of the sorted chain: holds one entry and shifts with its neighbors.
`timescale 1ns / 1ps
module psq_cell
    import psq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl,
    input  entry_t     left_entry,
    input  logic       left_ins,
    input  entry_t     right_entry,
    output entry_t     entry,
    output entry_t     entry_next,
    output logic       ins
);

    logic                    valid_reg;
    logic [ELEMENT_BITS-1:0] element_reg;
    logic [PRIO_BITS-1:0]    prio_reg;

    assign entry = '{valid: valid_reg, element: element_reg, prio: prio_reg};
    assign ins   = !valid_reg || (ctrl.prio >= prio_reg);

    always_comb begin
        entry_next = entry;
        if (ctrl.push) begin
            if (left_ins) begin
                entry_next = left_entry;
            end else if (ins) begin
                entry_next = '{valid: 1'b1, element: ctrl.element, prio: ctrl.prio};
            end
        end else if (ctrl.pop) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= entry_next.valid;
        end
        element_reg <= entry_next.element;
        prio_reg    <= entry_next.prio;
    end

endmodule

@@ design/priority_stack_queue_top.sv @@
// Top level: priority stack queue built from a chain of shifting cells.
`timescale 1ns / 1ps
// Bounded priority queue of CAPACITY entries, kept sorted by descending priority,
// newest first among equal priorities. Each transaction is a push or a pop and
// yields one result with the front entry, count, empty flag and status. Every cell
// compares the pushed priority in parallel and the whole row shifts at once, so a
// transaction can be taken every cycle while the output is not stalled. The result
// appears in a single output register in the cycle after acceptance. The input is
// ready only while that register is empty or being drained in the same cycle, so a
// stalled result holds off the input. A push to a full queue is dropped with status
// full, a pop of an empty queue is a no-op with status empty.
module priority_stack_queue_top
    import psq_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  m_valid_reg;
    out_t                  m_data_reg;
    out_t                  m_data_next;

    logic       accept;
    logic       is_full;
    logic       is_zero;
    logic       push_ok;
    logic       pop_ok;
    cell_ctrl_t ctrl;

    entry_t cell_entry [CAPACITY];
    entry_t cell_next  [CAPACITY];
    logic   cell_ins   [CAPACITY];
    logic [CAPACITY-1:0] valid_vec;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign is_full = (count_reg == COUNT_BITS'(CAPACITY));
    assign is_zero = (count_reg == '0);
    assign push_ok = accept && (s_data.opcode == OP_PUSH) && !is_full;
    assign pop_ok  = accept && (s_data.opcode == OP_POP) && !is_zero;

    assign ctrl = '{push: push_ok, pop: pop_ok, element: s_data.element, prio: s_data.prio};

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        entry_t left_e;
        logic   left_i;
        entry_t right_e;

        if (i == 0) begin : g_first
            assign left_e = '0;
            assign left_i = 1'b0;
        end else begin : g_mid
            assign left_e = cell_entry[i-1];
            assign left_i = cell_ins[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_e = '0;
        end else begin : g_inner
            assign right_e = cell_entry[i+1];
        end

        psq_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .left_entry  (left_e),
            .left_ins    (left_i),
            .right_entry (right_e),
            .entry       (cell_entry[i]),
            .entry_next  (cell_next[i]),
            .ins         (cell_ins[i])
        );

        assign valid_vec[i] = cell_entry[i].valid;
    end

    always_comb begin
        count_next = count_reg;
        if (push_ok) begin
            count_next = count_reg + 1'b1;
        end else if (pop_ok) begin
            count_next = count_reg - 1'b1;
        end

        m_data_next.count    = count_next;
        m_data_next.is_empty = (count_next == '0);
        if (cell_next[0].valid) begin
            m_data_next.front_element = cell_next[0].element;
            m_data_next.front_prio    = cell_next[0].prio;
        end else begin
            m_data_next.front_element = '0;
            m_data_next.front_prio    = '0;
        end

        if ((s_data.opcode == OP_PUSH) && is_full) begin
            m_data_next.status = ST_FULL;
        end else if ((s_data.opcode == OP_POP) && is_zero) begin
            m_data_next.status = ST_EMPTY;
        end else begin
            m_data_next.status = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_BITS'(CAPACITY))
        else $error("entry count above capacity");

    a_count_matches_cells: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == int'(count_reg))
        else $error("entry count disagrees with valid cells");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        push_ok |=> count_reg == $past(count_reg) + 1'b1)
        else $error("accepted push did not add an entry");

    a_front_is_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (cell_entry[0].valid && cell_entry[1].valid) |->
            cell_entry[1].prio <= cell_entry[0].prio)
        else $error("front entry is not of highest priority");

endmodule
